// ===== rtl/imu_bc_pkg.sv =====
package imu_bc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = 24;
    localparam int CNT_W     = 12;
    localparam int CAL_SUM_W = 28;

    // shared divider: widest dividend is a calibration sum, widest divisor is 4096
    localparam int DIV_DW = 28;
    localparam int DIV_VW = 13;

    localparam int G_W    = 21;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + G_W;

    localparam logic signed [SAMPLE_W:0] ONE_G_Q12 = 17'sd4096;
    localparam logic signed [G_W-1:0]    G_Q16     = 21'sd642908;
    localparam logic [DIV_VW-1:0]        CAL_WRAP_N = 13'd4096;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 12;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_COUNT  = 1'd1;

    localparam logic [11:0] CAL_COUNT_RESET = 12'd500;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

// ===== rtl/imu_bc_div.sv =====
module imu_bc_div
    import imu_bc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIV_DW-1:0] dividend,
    input  logic [DIV_VW-1:0]        divisor,
    output logic                     done,
    output logic signed [DIV_DW-1:0] quotient
);

    localparam int STEP_W = $clog2(DIV_DW + 1);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              neg_reg;
    logic [DIV_DW-1:0] mag_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_VW-1:0] dsr_reg;

    logic [DIV_VW:0] rem_sh;
    logic [DIV_VW:0] rem_dif;
    logic            ge;

    // one restoring step a cycle on magnitudes; sign applied at the end
    assign rem_sh  = {rem_reg, mag_reg[DIV_DW-1]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_dif = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= STEP_W'(DIV_DW);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DIV_DW-1];
            mag_reg <= dividend[DIV_DW-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (run_reg) begin
            mag_reg <= {mag_reg[DIV_DW-2:0], ge};
            rem_reg <= ge ? rem_dif[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

// ===== rtl/imu_bias_calibrate_moving_average.sv =====
// Calibrating word: s_ready returns after the accumulate state; the word that completes
// calibration holds s_ready low through three shared divisions (the x, y, z offsets).
// Filtered word: m_valid rises after window read/update, six divisions in the shared
// divider, three multiply/scale steps and the output load. A new word is taken only
// once the last is done: s_ready is high only while idle, and a result still held in the
// output register delays the next load. aresetn (synchronous, active low) clears control,
// configuration, calibration and window-sum state; the window memory is not cleared.
module imu_bias_calibrate_moving_average
    import imu_bc_pkg::*;
#(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sample_t              s_accel_x,
    input  sample_t              s_accel_y,
    input  sample_t              s_accel_z,
    input  sample_t              s_gyro_x,
    input  sample_t              s_gyro_y,
    input  sample_t              s_gyro_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output acc_t                 m_mean_accel_x_ms2,
    output acc_t                 m_mean_accel_y_ms2,
    output acc_t                 m_mean_accel_z_ms2,
    output sample_t              m_mean_gyro_x,
    output sample_t              m_mean_gyro_y,
    output sample_t              m_mean_gyro_z
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int WSUM_W = SAMPLE_W + FILL_W;
    localparam int ROW_W  = 6 * SAMPLE_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CAL_ACC = 4'd1;
    localparam logic [3:0] ST_DIV_GO  = 4'd2;
    localparam logic [3:0] ST_DIV_WT  = 4'd3;
    localparam logic [3:0] ST_MUL     = 4'd4;
    localparam logic [3:0] ST_SCALE   = 4'd5;
    localparam logic [3:0] ST_FILT_RD = 4'd6;
    localparam logic [3:0] ST_FILT_UP = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [3:0] state_reg, state_next;

    // configuration registers
    logic             cal_en_reg;
    logic [CNT_W-1:0] cal_cnt_reg;

    // calibration and window state
    logic                        calibrated_reg;
    logic [CNT_W-1:0]            seen_reg;
    logic signed [CAL_SUM_W-1:0] csum_reg [3];
    sample_t                     off_reg  [3];
    logic signed [WSUM_W-1:0]    wsum_reg [6];
    logic [FILL_W-1:0]           fill_reg;
    logic [SLOT_W-1:0]           slot_reg;

    // per-word working registers
    sample_t                  samp_reg [6];
    logic [2:0]               axis_reg;
    logic                     filt_reg;
    sample_t                  mean_reg;
    logic signed [PROD_W-1:0] prod_reg;
    acc_t                     res_acc_reg  [3];
    sample_t                  res_gyro_reg [3];
    logic                     m_valid_reg;

    // window memory: one row holds all six axes of one word
    logic [ROW_W-1:0] win_mem [WINDOW_DEPTH];
    logic [ROW_W-1:0] rd_row_reg;
    logic             win_we;

    logic signed [DIV_DW-1:0] div_dividend;
    logic [DIV_VW-1:0]        div_divisor;
    logic                     div_done;
    logic signed [DIV_DW-1:0] div_q;

    logic [CNT_W-1:0]         seen_inc;
    logic                     cal_complete;
    logic signed [SAMPLE_W:0] z_off;
    sample_t                  z_off_sat;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_adj;
    logic [1:0]               gyro_idx;
    logic                     win_full;
    logic                     out_free;
    logic                     accept;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign win_full = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign win_we   = (state_reg == ST_FILT_UP);

    assign seen_inc     = seen_reg + 1'b1;
    assign cal_complete = (seen_inc >= cal_cnt_reg) || (seen_inc == '0);

    // z offset: take off 1 g, clamp to the sample range
    assign z_off     = {div_q[SAMPLE_W-1], div_q[SAMPLE_W-1:0]} - ONE_G_Q12;
    assign z_off_sat = (z_off[SAMPLE_W] != z_off[SAMPLE_W-1])
                     ? {z_off[SAMPLE_W], {(SAMPLE_W-1){~z_off[SAMPLE_W]}}}
                     : z_off[SAMPLE_W-1:0];

    assign diff     = {mean_reg[SAMPLE_W-1], mean_reg}
                    - {off_reg[axis_reg[1:0]][SAMPLE_W-1], off_reg[axis_reg[1:0]]};
    // divide by 65536 toward zero: bias negatives before the shift
    assign prod_adj = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));

    // gyro axes 3..5 land in result slots 0..2
    assign gyro_idx = axis_reg[1:0] + 2'd1;

    // operand select for the shared divider
    always_comb begin
        if (filt_reg) begin
            div_dividend = {{(DIV_DW-WSUM_W){wsum_reg[axis_reg][WSUM_W-1]}},
                            wsum_reg[axis_reg]};
            div_divisor  = {{(DIV_VW-FILL_W){1'b0}}, fill_reg};
        end else begin
            div_dividend = csum_reg[axis_reg[1:0]];
            div_divisor  = (seen_reg == '0) ? CAL_WRAP_N : {1'b0, seen_reg};
        end
    end

    imu_bc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIV_GO),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!calibrated_reg && cal_en_reg) begin
                        state_next = ST_CAL_ACC;
                    end else begin
                        state_next = ST_FILT_RD;
                    end
                end
            end
            ST_CAL_ACC: begin
                state_next = cal_complete ? ST_DIV_GO : ST_IDLE;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WT;
            end
            ST_DIV_WT: begin
                if (div_done) begin
                    if (!filt_reg) begin
                        state_next = (axis_reg == 3'd2) ? ST_IDLE : ST_DIV_GO;
                    end else if (axis_reg < 3'd3) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = (axis_reg == 3'd5) ? ST_DONE : ST_DIV_GO;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_DIV_GO;
            end
            ST_FILT_RD: begin
                state_next = ST_FILT_UP;
            end
            ST_FILT_UP: begin
                state_next = ST_DIV_GO;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cal_en_reg     <= 1'b1;
            cal_cnt_reg    <= CAL_COUNT_RESET;
            calibrated_reg <= 1'b0;
            seen_reg       <= '0;
            fill_reg       <= '0;
            slot_reg       <= '0;
            axis_reg       <= '0;
            filt_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                csum_reg[i] <= '0;
                off_reg[i]  <= '0;
            end
            for (int i = 0; i < 6; i++) begin
                wsum_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CAL_ENABLE: cal_en_reg  <= cfg_wdata[0];
                    REG_CAL_COUNT:  cal_cnt_reg <= cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            // load a new result word or drop the one just taken
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    axis_reg <= '0;
                    if (accept) begin
                        filt_reg <= calibrated_reg || !cal_en_reg;
                        // enable dropped before completion: discard partial sums
                        if (!calibrated_reg && !cal_en_reg) begin
                            calibrated_reg <= 1'b1;
                            seen_reg       <= '0;
                            for (int i = 0; i < 3; i++) begin
                                csum_reg[i] <= '0;
                                off_reg[i]  <= '0;
                            end
                        end
                    end
                end
                ST_CAL_ACC: begin
                    seen_reg <= seen_inc;
                    for (int i = 0; i < 3; i++) begin
                        csum_reg[i] <= csum_reg[i] + CAL_SUM_W'(samp_reg[i]);
                    end
                end
                ST_DIV_WT: begin
                    if (div_done) begin
                        if (!filt_reg) begin
                            off_reg[axis_reg[1:0]] <= (axis_reg == 3'd2)
                                                    ? z_off_sat : div_q[SAMPLE_W-1:0];
                            axis_reg <= axis_reg + 1'b1;
                            if (axis_reg == 3'd2) begin
                                calibrated_reg <= 1'b1;
                            end
                        end else if (axis_reg >= 3'd3) begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end
                end
                ST_SCALE: begin
                    axis_reg <= axis_reg + 1'b1;
                end
                ST_FILT_UP: begin
                    for (int i = 0; i < 6; i++) begin
                        wsum_reg[i] <= wsum_reg[i] + WSUM_W'(samp_reg[i])
                                     - (win_full ? WSUM_W'($signed(
                                         rd_row_reg[i*SAMPLE_W +: SAMPLE_W])) : WSUM_W'(0));
                    end
                    if (!win_full) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    slot_reg <= (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                              ? '0 : slot_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // window memory: registered read of the slot about to be overwritten
    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[slot_reg] <= {samp_reg[5], samp_reg[4], samp_reg[3],
                                  samp_reg[2], samp_reg[1], samp_reg[0]};
        end
        rd_row_reg <= win_mem[slot_reg];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            samp_reg[0] <= s_accel_x;
            samp_reg[1] <= s_accel_y;
            samp_reg[2] <= s_accel_z;
            samp_reg[3] <= s_gyro_x;
            samp_reg[4] <= s_gyro_y;
            samp_reg[5] <= s_gyro_z;
        end
        if (state_reg == ST_DIV_WT && div_done && filt_reg) begin
            if (axis_reg < 3'd3) begin
                mean_reg <= div_q[SAMPLE_W-1:0];
            end else begin
                res_gyro_reg[gyro_idx] <= div_q[SAMPLE_W-1:0];
            end
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= diff * G_Q16;
        end
        if (state_reg == ST_SCALE) begin
            // scaled value always fits; sign-extend the shifted product
            res_acc_reg[axis_reg[1:0]] <= ACC_W'($signed(prod_adj[PROD_W-1:16]));
        end
        if (state_reg == ST_DONE && out_free) begin
            m_mean_accel_x_ms2 <= res_acc_reg[0];
            m_mean_accel_y_ms2 <= res_acc_reg[1];
            m_mean_accel_z_ms2 <= res_acc_reg[2];
            m_mean_gyro_x      <= res_gyro_reg[0];
            m_mean_gyro_y      <= res_gyro_reg[1];
            m_mean_gyro_z      <= res_gyro_reg[2];
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/imu_bc_checker.sv =====
module imu_bc_checker
    import imu_bc_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input acc_t    m_mean_accel_x_ms2,
    input sample_t m_mean_gyro_x
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_accel_x_ms2)
                                && $stable(m_mean_gyro_x))
        else $error("stalled result word changed");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an accepted word leaves s_ready low in the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    // a new result never appears while the block is idle
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised without work in progress");

endmodule

bind imu_bias_calibrate_moving_average imu_bc_checker u_imu_bc_checker (.*);

// ===== tb/imu_bias_calibrate_moving_average_tb.sv =====
`timescale 1ns / 1ps

module imu_bias_calibrate_moving_average_tb;
    import imu_bc_pkg::*;

    localparam int DEPTH      = 10;
    localparam int SETTLE     = 400;   // beyond the slowest word
    localparam int RAND_WORDS = 2000;

    typedef struct {
        sample_t ax, ay, az, gx, gy, gz;
    } imu_sample_t;

    typedef struct {
        acc_t    ax, ay, az;
        sample_t gx, gy, gz;
    } imu_mean_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DW-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    sample_t              s_accel_x, s_accel_y, s_accel_z;
    sample_t              s_gyro_x, s_gyro_y, s_gyro_z;
    logic                 m_valid;
    logic                 m_ready;
    acc_t                 m_mean_accel_x_ms2, m_mean_accel_y_ms2, m_mean_accel_z_ms2;
    sample_t              m_mean_gyro_x, m_mean_gyro_y, m_mean_gyro_z;

    imu_bias_calibrate_moving_average #(.WINDOW_DEPTH(DEPTH)) dut (.*);

    // Samples waiting for the driver and means waiting for the monitor.
    imu_sample_t sample_q[$];
    imu_mean_t   expected_means[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;

    // Shadow of the block: registers, calibration and window state.
    bit          sh_cal_en;
    logic [11:0] sh_cal_cnt;
    bit          sh_calibrated;
    logic [11:0] sh_seen;
    longint      sh_cal_sum[3];
    longint      sh_offset[3];
    longint      sh_window[DEPTH][6];
    longint      sh_win_sum[6];
    int          sh_fill;
    int          sh_slot;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Append a word to the driver's pending list.
    function automatic void add_word(imu_sample_t smp);
        sample_q = {sample_q, smp};
    endfunction

    // Advance the shadow by one accepted word; queue the mean it produces, if any.
    function automatic void filter_sample(imu_sample_t smp);
        longint v[6];
        longint n, mean, scaled;
        imu_mean_t r;
        v = '{smp.ax, smp.ay, smp.az, smp.gx, smp.gy, smp.gz};
        if (!sh_calibrated) begin
            if (!sh_cal_en) begin
                // enable dropped mid-calibration: discard sums, filter this word
                sh_calibrated = 1'b1;
                sh_seen = '0;
                sh_cal_sum = '{0, 0, 0};
                sh_offset = '{0, 0, 0};
            end else begin
                for (int i = 0; i < 3; i++) sh_cal_sum[i] += v[i];
                sh_seen = sh_seen + 12'd1;
                if (sh_seen >= sh_cal_cnt || sh_seen == 0) begin
                    n = (sh_seen == 0) ? 4096 : longint'(sh_seen);
                    for (int i = 0; i < 3; i++) sh_offset[i] = sh_cal_sum[i] / n;
                    // z holds 1 g at rest; clamp its offset to the sample range
                    sh_offset[2] -= 4096;
                    if (sh_offset[2] > 32767) sh_offset[2] = 32767;
                    if (sh_offset[2] < -32768) sh_offset[2] = -32768;
                    sh_calibrated = 1'b1;
                end
                return;
            end
        end
        if (sh_fill >= DEPTH) begin
            for (int i = 0; i < 6; i++) sh_win_sum[i] -= sh_window[sh_slot][i];
        end else begin
            sh_fill++;
        end
        for (int i = 0; i < 6; i++) begin
            sh_window[sh_slot][i] = v[i];
            sh_win_sum[i] += v[i];
        end
        sh_slot = (sh_slot + 1) % DEPTH;
        for (int i = 0; i < 6; i++) begin
            mean = sh_win_sum[i] / sh_fill;
            if (i < 3) begin
                scaled = ((mean - sh_offset[i]) * 642908) / 65536;
                case (i)
                    0: r.ax = acc_t'(scaled);
                    1: r.ay = acc_t'(scaled);
                    default: r.az = acc_t'(scaled);
                endcase
            end else begin
                case (i)
                    3: r.gx = sample_t'(mean);
                    4: r.gy = sample_t'(mean);
                    default: r.gz = sample_t'(mean);
                endcase
            end
        end
        expected_means = {expected_means, r};
    endfunction

    // Driver: predict on accept, then present the next word or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                filter_sample('{s_accel_x, s_accel_y, s_accel_z, s_gyro_x, s_gyro_y, s_gyro_z});
            if (!s_valid || s_ready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    imu_sample_t nxt;
                    nxt = sample_q[0];
                    sample_q.delete(0);
                    s_accel_x <= nxt.ax;
                    s_accel_y <= nxt.ay;
                    s_accel_z <= nxt.az;
                    s_gyro_x  <= nxt.gx;
                    s_gyro_y  <= nxt.gy;
                    s_gyro_z  <= nxt.gz;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted mean against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_means.size() == 0) begin
                    $error("unexpected mean word");
                    errors++;
                end else begin
                    imu_mean_t e;
                    e = expected_means[0];
                    expected_means.delete(0);
                    if (m_mean_accel_x_ms2 !== e.ax) begin
                        $error("mean_accel_x_ms2 exp %0d got %0d", e.ax, m_mean_accel_x_ms2);
                        errors++;
                    end
                    if (m_mean_accel_y_ms2 !== e.ay) begin
                        $error("mean_accel_y_ms2 exp %0d got %0d", e.ay, m_mean_accel_y_ms2);
                        errors++;
                    end
                    if (m_mean_accel_z_ms2 !== e.az) begin
                        $error("mean_accel_z_ms2 exp %0d got %0d", e.az, m_mean_accel_z_ms2);
                        errors++;
                    end
                    if (m_mean_gyro_x !== e.gx) begin
                        $error("mean_gyro_x exp %0d got %0d", e.gx, m_mean_gyro_x);
                        errors++;
                    end
                    if (m_mean_gyro_y !== e.gy) begin
                        $error("mean_gyro_y exp %0d got %0d", e.gy, m_mean_gyro_y);
                        errors++;
                    end
                    if (m_mean_gyro_z !== e.gz) begin
                        $error("mean_gyro_z exp %0d got %0d", e.gz, m_mean_gyro_z);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Random field, leaning toward the rails now and then.
    function automatic sample_t rand_field();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return sample_t'($urandom_range(15)) - 16'sd8;
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic imu_sample_t rand_sample();
        return '{rand_field(), rand_field(), rand_field(),
                 rand_field(), rand_field(), rand_field()};
    endfunction

    // Write a register and mirror it in the shadow; only called while idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == REG_CAL_ENABLE) sh_cal_en = data[0];
        else sh_cal_cnt = data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued word is taken and every mean is back, then
    // let calibrating words that produce no mean finish in the block.
    task automatic drain();
        while (sample_q.size() != 0 || s_valid || expected_means.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        errors        = 0;
        send_idle_pct = 37;
        recv_idle_pct = 88;
        sh_cal_en     = 1'b1;
        sh_cal_cnt    = CAL_COUNT_RESET;
        sh_calibrated = 1'b0;
        sh_seen       = '0;
        sh_cal_sum    = '{0, 0, 0};
        sh_offset     = '{0, 0, 0};
        sh_win_sum    = '{0, 0, 0, 0, 0, 0};
        sh_fill       = 0;
        sh_slot       = 0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Calibrate toward the largest count, then lower it below the words
        // seen so calibration completes on the next word.
        write_reg(REG_CAL_ENABLE, 12'd1);
        write_reg(REG_CAL_COUNT, 12'd4095);
        add_word('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh8000});
        add_word('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh7FFF});
        add_word('{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000});
        add_word('{16'sh0001, 16'shFFFF, 16'sh1000, 16'shFFFF, 16'sh0001, 16'sh0000});
        drain();
        write_reg(REG_CAL_COUNT, 12'd1);
        // completing word: gathered, no mean
        add_word('{16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh1234, 16'shEDCC, 16'sh0000});
        drain();

        // Registers have no effect once calibrated; exercise their extremes.
        write_reg(REG_CAL_ENABLE, 12'd0);
        write_reg(REG_CAL_COUNT, 12'd0);

        // Fill the window past its depth with one rail, then the other rail.
        for (int k = 0; k < 12; k++)
            add_word('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        for (int k = 0; k < 6; k++)
            add_word('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        add_word('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
        drain();
        write_reg(REG_CAL_ENABLE, 12'd1);
        write_reg(REG_CAL_COUNT, 12'd4095);

        // Random words over three idling regimes.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 37 : 0;
            for (int k = 0; k < RAND_WORDS / 3; k++) add_word(rand_sample());
            drain();
        end

        if (errors == 0 && expected_means.size() == 0) begin
            $display("imu_bias_calibrate_moving_average_tb passed");
        end else begin
            $display("imu_bias_calibrate_moving_average_tb failed");
        end
        $finish;
    end

    // Watchdog: well above the slowest correct run.
    initial begin
        #10ms;
        $display("imu_bias_calibrate_moving_average_tb failed");
        $finish;
    end

endmodule
